// ===== hdl/onewire_bus_master_sequencer_core_defines.svh =====
// Assertion macros for the 1-Wire master sequencer core.
// Used by the modules under hdl/ that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef ONEWIRE_BUS_MASTER_SEQUENCER_CORE_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define OWMS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("owms check failed");

// Implication: when ante holds, cons must hold in the same cycle.
`define OWMS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("owms check failed");

// Implication: when ante holds, cons must hold in the cycle after.
`define OWMS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("owms check failed");

`else

`define OWMS_ASSERT(name, prop)
`define OWMS_ASSERT_IMP(name, ante, cons)
`define OWMS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== hdl/owms_pkg.sv =====
// Shared types, constants and helpers for the 1-Wire master sequencer core.
// No dependencies; used by owms_bitbuf, owms_seq and the top level.
package owms_pkg;

  localparam int BUFFER_BITS = 80;
  localparam int BUF_AW      = $clog2(BUFFER_BITS);
  localparam int FIELD_W     = 7;   // index and count fields
  localparam int WAIT_W      = 10;

  // Bus timing, in microsecond ticks
  localparam logic [WAIT_W-1:0] T_IDLE         = WAIT_W'(100);
  localparam logic [WAIT_W-1:0] T_START        = WAIT_W'(100);
  localparam logic [WAIT_W-1:0] T_RESET        = WAIT_W'(600);
  localparam logic [WAIT_W-1:0] T_RESET_WAIT   = WAIT_W'(15);
  localparam logic [WAIT_W-1:0] T_PRESENCE     = WAIT_W'(40);
  localparam logic [WAIT_W-1:0] T_PRESENCE_END = WAIT_W'(300);
  localparam logic [WAIT_W-1:0] T_LOW          = WAIT_W'(2);
  localparam logic [WAIT_W-1:0] T_SLOT         = WAIT_W'(60);
  localparam logic [WAIT_W-1:0] T_DATA_WAIT    = WAIT_W'(15);
  localparam logic [WAIT_W-1:0] T_END          = WAIT_W'(5);
  localparam logic [WAIT_W-1:0] T_SLAVE        = WAIT_W'(5);

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_START = 3'd2,
    OP_RESET = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    PH_INIT       = 4'd0,
    PH_IDLE       = 4'd1,
    PH_ERROR      = 4'd2,
    PH_RST_START  = 4'd3,
    PH_RST_END    = 4'd4,
    PH_PRES_START = 4'd5,
    PH_PRES_END   = 4'd6,
    PH_WR_BEGIN   = 4'd7,
    PH_WR_SET     = 4'd8,
    PH_WR_END     = 4'd9,
    PH_WR_NEXT    = 4'd10,
    PH_RD_BEGIN   = 4'd11,
    PH_RD_SET     = 4'd12,
    PH_RD_END     = 4'd13,
    PH_RD_NEXT    = 4'd14,
    PH_END        = 4'd15
  } phase_e;

  // Bit buffer access request, one per accepted transfer
  typedef struct packed {
    logic              wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic              wr_data;
    logic              rd_en;
    logic [BUF_AW-1:0] rd_addr;
    logic              clr_all;
    logic              clr_tail;   // clear entries at and above tail_from
    logic [FIELD_W-1:0] tail_from;
  } buf_req_t;

  // Status after the last accepted transfer
  typedef struct packed {
    logic   bus_out;
    logic   ready_res;
    logic   busy_res;
    logic   read_bit;
    phase_e phase;
  } res_t;

  function automatic logic in_range(logic [FIELD_W-1:0] idx);
    return (32'(idx) < 32'(BUFFER_BITS));
  endfunction

  function automatic logic [FIELD_W-1:0] clamp_count(logic [FIELD_W-1:0] cnt);
    return (32'(cnt) > 32'(BUFFER_BITS)) ? FIELD_W'(BUFFER_BITS) : cnt;
  endfunction

endpackage

// ===== hdl/owms_bitbuf.sv =====
// Transmit/receive bit buffer: synchronous RAM with registered read and per-entry valid bits.
// Depends on owms_pkg; an entry never written since its last clear reads as zero.
module owms_bitbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  owms_pkg::buf_req_t req_i,
  output logic               rd_bit_o
);

  logic                             mem_q [owms_pkg::BUFFER_BITS];
  logic [owms_pkg::BUFFER_BITS-1:0] valid_q;
  logic                             rd_data_q;
  logic                             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
      if (req_i.clr_all) begin
        valid_q <= '0;
      end else begin
        if (req_i.clr_tail) begin
          for (int i = 0; i < owms_pkg::BUFFER_BITS; i++) begin
            if (32'(i) >= 32'(req_i.tail_from)) begin
              valid_q[i] <= 1'b0;
            end
          end
        end
        if (req_i.wr_en) begin
          valid_q[req_i.wr_addr] <= 1'b1;
        end
      end
    end
  end

  assign rd_bit_o = rd_data_q & rd_valid_q;

endmodule

// ===== hdl/owms_seq.sv =====
// Sequencer: tick timer, bus phase machine, counters and bit buffer request generation.
// Depends on owms_pkg and the assertion macros header.
`include "onewire_bus_master_sequencer_core_defines.svh"

module owms_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [2:0]                    op_i,
  input  logic                          bus_in_i,
  input  logic                          bit_value_i,
  input  logic [owms_pkg::FIELD_W-1:0]  bit_index_i,
  input  logic [owms_pkg::FIELD_W-1:0]  tx_count_i,
  input  logic [owms_pkg::FIELD_W-1:0]  rx_count_i,
  input  logic                          buf_rd_bit_i,
  output owms_pkg::buf_req_t            buf_req_o,
  output owms_pkg::res_t                res_o
);

  owms_pkg::phase_e                phase_q, phase_d;
  logic [owms_pkg::FIELD_W-1:0]    send_q, send_d;
  logic [owms_pkg::FIELD_W-1:0]    read_q, read_d;
  logic [owms_pkg::FIELD_W-1:0]    slot_q, slot_d;
  logic [owms_pkg::WAIT_W-1:0]     period_q, period_d;
  logic [owms_pkg::WAIT_W-1:0]     wait_q, wait_d;
  logic                            ready_q, ready_d;
  logic                            drive_q, drive_d;
  logic                            drive_pend_q, drive_pend_d;  // drive level sits in RAM data
  logic                            rst_pend_q, rst_pend_d;
  logic                            rd_op_q, rd_op_d;
  logic                            busy;
  logic                            drive_eff;
  logic [owms_pkg::FIELD_W-1:0]    slot_inc;
  owms_pkg::phase_e                ph;
  owms_pkg::op_e                   op;

  assign op        = owms_pkg::op_e'(op_i);
  assign busy      = (send_q != '0) || (read_q != '0);
  assign drive_eff = drive_pend_q ? buf_rd_bit_i : drive_q;
  assign slot_inc  = slot_q + owms_pkg::FIELD_W'(1);
  // A pending reset request turns the next step into an init step
  assign ph        = rst_pend_q ? owms_pkg::PH_INIT : phase_q;

  always_comb begin
    phase_d      = phase_q;
    send_d       = send_q;
    read_d       = read_q;
    slot_d       = slot_q;
    period_d     = period_q;
    wait_d       = wait_q;
    ready_d      = ready_q;
    drive_d      = drive_q;
    drive_pend_d = drive_pend_q;
    rst_pend_d   = rst_pend_q;
    rd_op_d      = rd_op_q;
    buf_req_o    = '0;

    if (accept_i) begin
      drive_d      = drive_eff;
      drive_pend_d = 1'b0;
      rd_op_d      = 1'b0;
      unique case (op)
        owms_pkg::OP_TICK: begin
          if (wait_q != '0) begin
            wait_d = wait_q - owms_pkg::WAIT_W'(1);
          end else begin
            unique case (ph)
              owms_pkg::PH_INIT: begin
                buf_req_o.clr_all = 1'b1;
                send_d     = '0;
                read_d     = '0;
                slot_d     = '0;
                ready_d    = 1'b0;
                rst_pend_d = 1'b0;
                drive_d    = 1'b1;
                period_d   = owms_pkg::T_IDLE;
                phase_d    = owms_pkg::PH_IDLE;
              end
              owms_pkg::PH_IDLE: begin
                if (send_q == owms_pkg::FIELD_W'(1)) begin
                  drive_d  = 1'b1;
                  period_d = owms_pkg::T_DATA_WAIT;
                  phase_d  = owms_pkg::PH_WR_BEGIN;
                end else if (send_q != '0) begin
                  drive_d  = 1'b1;
                  period_d = owms_pkg::T_START;
                  phase_d  = owms_pkg::PH_RST_START;
                end else if (read_q != '0) begin
                  drive_d  = 1'b1;
                  period_d = owms_pkg::T_START;
                  phase_d  = owms_pkg::PH_RD_BEGIN;
                end
              end
              owms_pkg::PH_ERROR: begin
                buf_req_o.clr_all = 1'b1;
                send_d     = '0;
                read_d     = '0;
                slot_d     = '0;
                ready_d    = 1'b0;
                rst_pend_d = 1'b0;
                period_d   = owms_pkg::T_IDLE;
                phase_d    = owms_pkg::PH_END;
              end
              owms_pkg::PH_RST_START: begin
                period_d = owms_pkg::T_RESET;
                drive_d  = 1'b0;
                phase_d  = owms_pkg::PH_RST_END;
              end
              owms_pkg::PH_RST_END: begin
                period_d = owms_pkg::T_RESET_WAIT;
                drive_d  = 1'b1;
                phase_d  = owms_pkg::PH_PRES_START;
              end
              owms_pkg::PH_PRES_START: begin
                period_d = owms_pkg::T_PRESENCE;
                phase_d  = bus_in_i ? owms_pkg::PH_PRES_END : owms_pkg::PH_ERROR;
              end
              owms_pkg::PH_PRES_END: begin
                period_d = owms_pkg::T_PRESENCE_END;
                phase_d  = bus_in_i ? owms_pkg::PH_ERROR : owms_pkg::PH_WR_BEGIN;
              end
              owms_pkg::PH_WR_BEGIN: begin
                if (send_q == '0) begin
                  phase_d = owms_pkg::PH_WR_NEXT;
                end else begin
                  period_d = owms_pkg::T_LOW;
                  drive_d  = 1'b0;
                  phase_d  = owms_pkg::PH_WR_SET;
                end
              end
              owms_pkg::PH_WR_SET: begin
                // Data bit comes back from RAM next cycle
                if (owms_pkg::in_range(slot_q)) begin
                  buf_req_o.rd_en   = 1'b1;
                  buf_req_o.rd_addr = owms_pkg::BUF_AW'(slot_q);
                  drive_pend_d      = 1'b1;
                end else begin
                  drive_d = 1'b0;
                end
                period_d = owms_pkg::T_SLOT;
                phase_d  = owms_pkg::PH_WR_END;
              end
              owms_pkg::PH_WR_END: begin
                period_d = owms_pkg::T_END;
                drive_d  = 1'b1;
                phase_d  = owms_pkg::PH_WR_NEXT;
              end
              owms_pkg::PH_WR_NEXT: begin
                if (slot_inc < send_q) begin
                  slot_d  = slot_inc;
                  phase_d = owms_pkg::PH_WR_BEGIN;
                end else begin
                  slot_d   = '0;
                  period_d = owms_pkg::T_SLOT;
                  phase_d  = owms_pkg::PH_RD_BEGIN;
                end
              end
              owms_pkg::PH_RD_BEGIN: begin
                if (read_q == '0) begin
                  phase_d = owms_pkg::PH_RD_NEXT;
                end else begin
                  period_d = owms_pkg::T_LOW;
                  drive_d  = 1'b0;
                  phase_d  = owms_pkg::PH_RD_SET;
                end
              end
              owms_pkg::PH_RD_SET: begin
                period_d = owms_pkg::T_SLAVE;
                drive_d  = 1'b1;
                phase_d  = owms_pkg::PH_RD_END;
              end
              owms_pkg::PH_RD_END: begin
                if (owms_pkg::in_range(slot_q)) begin
                  buf_req_o.wr_en   = 1'b1;
                  buf_req_o.wr_addr = owms_pkg::BUF_AW'(slot_q);
                  buf_req_o.wr_data = bus_in_i;
                end
                period_d = owms_pkg::T_SLOT;
                phase_d  = owms_pkg::PH_RD_NEXT;
              end
              owms_pkg::PH_RD_NEXT: begin
                slot_d   = slot_inc;
                period_d = owms_pkg::T_DATA_WAIT;
                if (slot_inc < read_q) begin
                  phase_d = owms_pkg::PH_RD_BEGIN;
                end else begin
                  // bits past the read count are dropped
                  buf_req_o.clr_tail  = 1'b1;
                  buf_req_o.tail_from = read_q;
                  ready_d = 1'b1;
                  send_d  = '0;
                  read_d  = '0;
                  phase_d = owms_pkg::PH_END;
                end
              end
              owms_pkg::PH_END: begin
                slot_d  = '0;
                phase_d = owms_pkg::PH_IDLE;
              end
            endcase
            wait_d = period_d;
          end
        end
        owms_pkg::OP_LOAD: begin
          if (!busy && owms_pkg::in_range(bit_index_i)) begin
            buf_req_o.wr_en   = 1'b1;
            buf_req_o.wr_addr = owms_pkg::BUF_AW'(bit_index_i);
            buf_req_o.wr_data = bit_value_i;
          end
        end
        owms_pkg::OP_START: begin
          if (!busy) begin
            send_d  = owms_pkg::clamp_count(tx_count_i);
            read_d  = owms_pkg::clamp_count(rx_count_i);
            ready_d = 1'b0;
          end
        end
        owms_pkg::OP_RESET: begin
          rst_pend_d = 1'b1;
        end
        owms_pkg::OP_READ: begin
          if (owms_pkg::in_range(bit_index_i)) begin
            buf_req_o.rd_en   = 1'b1;
            buf_req_o.rd_addr = owms_pkg::BUF_AW'(bit_index_i);
            rd_op_d           = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= owms_pkg::PH_INIT;
      send_q       <= '0;
      read_q       <= '0;
      slot_q       <= '0;
      period_q     <= '0;
      wait_q       <= '0;
      ready_q      <= 1'b0;
      drive_q      <= 1'b1;
      drive_pend_q <= 1'b0;
      rst_pend_q   <= 1'b0;
      rd_op_q      <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      send_q       <= send_d;
      read_q       <= read_d;
      slot_q       <= slot_d;
      period_q     <= period_d;
      wait_q       <= wait_d;
      ready_q      <= ready_d;
      drive_q      <= drive_d;
      drive_pend_q <= drive_pend_d;
      rst_pend_q   <= rst_pend_d;
      rd_op_q      <= rd_op_d;
    end
  end

  always_comb begin
    res_o.bus_out   = drive_eff;
    res_o.ready_res = ready_q;
    res_o.busy_res  = busy;
    res_o.read_bit  = rd_op_q & buf_rd_bit_i;
    res_o.phase     = phase_q;
  end

  // Completion clears the counts in the same step that flags ready
  `OWMS_ASSERT(a_ready_not_busy, !(ready_q && busy))
  // A tick that only counts down leaves the sequencer where it is
  `OWMS_ASSERT_NEXT(a_wait_holds_phase, accept_i && (op == owms_pkg::OP_TICK) && (wait_q != '0), $stable(phase_q))
  // One RAM access per transfer
  `OWMS_ASSERT(a_single_access, !(buf_req_o.wr_en && buf_req_o.rd_en))
  // Bus is pulled low only inside a reset pulse or a slot
  `OWMS_ASSERT_IMP(a_low_in_slot, !drive_eff, (phase_q == owms_pkg::PH_RST_END) || (phase_q == owms_pkg::PH_WR_SET) || (phase_q == owms_pkg::PH_WR_END) || (phase_q == owms_pkg::PH_RD_SET))

endmodule

// ===== hdl/onewire_bus_master_sequencer_core.sv =====
// Channel   Handshake              Payload
// in        in_valid_i/in_ready_o  op_i bus_in_i bit_value_i bit_index_i tx_count_i rx_count_i
// out       out_valid_o/out_ready_i bus_out_o ready_res_o busy_res_o read_bit_o phase_o
//
// One transfer in per cycle while the output is not stalled; its result is offered on the next
// cycle from the output stage. Read bits come from the registered read of the bit buffer RAM.
// rst_ni clears the sequencer to init and empties the bit buffer through its valid bits at once.
// A stalled output holds the input off only while the held result is not taken.
// Depends on owms_pkg, owms_bitbuf and owms_seq.
module onewire_bus_master_sequencer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   op_i,
  input  logic                         bus_in_i,
  input  logic                         bit_value_i,
  input  logic [owms_pkg::FIELD_W-1:0] bit_index_i,
  input  logic [owms_pkg::FIELD_W-1:0] tx_count_i,
  input  logic [owms_pkg::FIELD_W-1:0] rx_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         bus_out_o,
  output logic                         ready_res_o,
  output logic                         busy_res_o,
  output logic                         read_bit_o,
  output logic [3:0]                   phase_o
);

  logic               out_valid_q;
  logic               accept;
  logic               buf_rd_bit;
  owms_pkg::buf_req_t buf_req;
  owms_pkg::res_t     res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  owms_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op_i),
    .bus_in_i     (bus_in_i),
    .bit_value_i  (bit_value_i),
    .bit_index_i  (bit_index_i),
    .tx_count_i   (tx_count_i),
    .rx_count_i   (rx_count_i),
    .buf_rd_bit_i (buf_rd_bit),
    .buf_req_o    (buf_req),
    .res_o        (res)
  );

  owms_bitbuf u_bitbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (buf_req),
    .rd_bit_o (buf_rd_bit)
  );

  assign out_valid_o = out_valid_q;
  assign bus_out_o   = res.bus_out;
  assign ready_res_o = res.ready_res;
  assign busy_res_o  = res.busy_res;
  assign read_bit_o  = res.read_bit;
  assign phase_o     = res.phase;

endmodule
